[hdl/obb_pkg.sv]
`timescale 1ns / 1ps

package obb_pkg;

    localparam int NUM_DIM = 3;
    localparam logic [7:0] ABS_BIAS_RESET = 8'd1;
    localparam int LATENCY = 5;

    // cyclic successor of an axis index
    function automatic int nxt(input int k);
        int r;
        unique case (k)
            0: r = 1;
            1: r = 2;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

[hdl/obb_quat_mat.sv]
`timescale 1ns / 1ps

module obb_quat_mat #(
    parameter int QB = 16
) (
    input  logic                 i_clk,
    input  logic signed [QB-1:0] i_w,
    input  logic signed [QB-1:0] i_x,
    input  logic signed [QB-1:0] i_y,
    input  logic signed [QB-1:0] i_z,
    output logic signed [QB-1:0] o_m [obb_pkg::NUM_DIM][obb_pkg::NUM_DIM]
);
    localparam int QF = QB - 2;
    localparam int PR = 2 * QB;
    localparam int EW = 2 * QB + 3;

    logic signed [PR-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [EW-1:0] n_e [3][3];
    logic signed [QB-1:0] r_m [3][3];

    always_ff @(posedge i_clk) begin
        r_xx <= PR'(i_x) * PR'(i_x);
        r_yy <= PR'(i_y) * PR'(i_y);
        r_zz <= PR'(i_z) * PR'(i_z);
        r_xy <= PR'(i_x) * PR'(i_y);
        r_xz <= PR'(i_x) * PR'(i_z);
        r_yz <= PR'(i_y) * PR'(i_z);
        r_wx <= PR'(i_w) * PR'(i_x);
        r_wy <= PR'(i_w) * PR'(i_y);
        r_wz <= PR'(i_w) * PR'(i_z);
    end

    always_comb begin
        logic signed [EW-1:0] s;
        logic signed [EW-1:0] v;
        s = EW'(1) <<< (2 * QF);
        n_e[0][0] = s - ((EW'(r_yy) + EW'(r_zz)) <<< 1);
        n_e[0][1] = (EW'(r_xy) + EW'(r_wz)) <<< 1;
        n_e[0][2] = (EW'(r_xz) - EW'(r_wy)) <<< 1;
        n_e[1][0] = (EW'(r_xy) - EW'(r_wz)) <<< 1;
        n_e[1][1] = s - ((EW'(r_xx) + EW'(r_zz)) <<< 1);
        n_e[1][2] = (EW'(r_yz) + EW'(r_wx)) <<< 1;
        n_e[2][0] = (EW'(r_xz) + EW'(r_wy)) <<< 1;
        n_e[2][1] = (EW'(r_yz) - EW'(r_wx)) <<< 1;
        n_e[2][2] = s - ((EW'(r_xx) + EW'(r_yy)) <<< 1);
        for (int i = 0; i < 3; i++) begin
            for (int r = 0; r < 3; r++) begin
                // round half up, then clamp to +-1.0
                v = (n_e[i][r] + (EW'(1) <<< (QF - 1))) >>> QF;
                if (v > (EW'(1) <<< QF)) begin
                    v = EW'(1) <<< QF;
                end else if (v < -(EW'(1) <<< QF)) begin
                    v = -(EW'(1) <<< QF);
                end
                n_e[i][r] = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int r = 0; r < 3; r++) begin
                r_m[i][r] <= QB'(n_e[i][r]);
            end
        end
    end

    assign o_m = r_m;

endmodule

[hdl/obb_sat.sv]
`timescale 1ns / 1ps

module obb_sat #(
    parameter int CW = 21,
    parameter int QB = 16
) (
    input  logic                 i_clk,
    input  logic [7:0]           i_bias,
    input  logic signed [QB-1:0] i_ma [obb_pkg::NUM_DIM][obb_pkg::NUM_DIM],
    input  logic signed [QB-1:0] i_mb [obb_pkg::NUM_DIM][obb_pkg::NUM_DIM],
    input  logic signed [CW:0]   i_diff [obb_pkg::NUM_DIM],
    input  logic signed [CW-1:0] i_ea [obb_pkg::NUM_DIM],
    input  logic signed [CW-1:0] i_eb [obb_pkg::NUM_DIM],
    output logic                 o_ok
);
    localparam int QF   = QB - 2;
    localparam int ACW  = 2 * QB + 2;
    localparam int RW   = ACW - QF;
    localparam int ARW  = RW + 2;
    localparam int TW   = CW + 1 + QB + 2;
    localparam int RDW  = CW + ARW + 3;
    localparam int PW   = TW + RW + 2;
    localparam int CMPW = ((PW > RDW + QF) ? PW : RDW + QF) + 2;

    // stage 3: relative rotation and offset in frame of A
    logic signed [RW-1:0]  r_rr [3][3];
    logic signed [ARW-1:0] r_ar [3][3];
    logic signed [TW-1:0]  r_t [3];
    logic signed [CW-1:0]  r_ea3 [3], r_eb3 [3];
    logic signed [RW-1:0]  n_rr [3][3];
    logic signed [ARW-1:0] n_ar [3][3];
    logic signed [TW-1:0]  n_t [3];

    always_comb begin
        logic signed [ACW-1:0] acc;
        logic signed [TW-1:0]  tacc;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = '0;
                for (int r = 0; r < 3; r++) begin
                    acc = acc + ACW'(i_ma[i][r]) * ACW'(i_mb[j][r]);
                end
                n_rr[i][j] = RW'((acc + (ACW'(1) <<< (QF - 1))) >>> QF);
                n_ar[i][j] = ((n_rr[i][j] < 0) ? -ARW'(n_rr[i][j]) : ARW'(n_rr[i][j]))
                           + ARW'($signed({1'b0, i_bias}));
            end
            tacc = '0;
            for (int r = 0; r < 3; r++) begin
                tacc = tacc + TW'(i_diff[r]) * TW'(i_ma[i][r]);
            end
            n_t[i] = tacc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rr  <= n_rr;
        r_ar  <= n_ar;
        r_t   <= n_t;
        r_ea3 <= i_ea;
        r_eb3 <= i_eb;
    end

    // stage 4: radii and projections for all 15 axes
    logic signed [RDW-1:0] r_rad_a [3], r_rad_b [3], r_rad_x [3][3];
    logic signed [TW-1:0]  r_t4 [3];
    logic signed [PW-1:0]  r_p_b [3], r_p_x [3][3];
    logic signed [RDW-1:0] n_rad_a [3], n_rad_b [3], n_rad_x [3][3];
    logic signed [PW-1:0]  n_p_b [3], n_p_x [3][3];

    always_comb begin
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++) begin
            n_rad_a[i] = RDW'(r_ea3[i]) <<< QF;
            n_rad_b[i] = RDW'(r_eb3[i]) <<< QF;
            n_p_b[i]   = '0;
            for (int k = 0; k < 3; k++) begin
                n_rad_a[i] = n_rad_a[i] + RDW'(r_eb3[k]) * RDW'(r_ar[i][k]);
                n_rad_b[i] = n_rad_b[i] + RDW'(r_ea3[k]) * RDW'(r_ar[k][i]);
                n_p_b[i]   = n_p_b[i] + PW'(r_t[k]) * PW'(r_rr[k][i]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            i1 = obb_pkg::nxt(i);
            i2 = obb_pkg::nxt(i1);
            for (int j = 0; j < 3; j++) begin
                j1 = obb_pkg::nxt(j);
                j2 = obb_pkg::nxt(j1);
                n_rad_x[i][j] = RDW'(r_ea3[i1]) * RDW'(r_ar[i2][j])
                              + RDW'(r_ea3[i2]) * RDW'(r_ar[i1][j])
                              + RDW'(r_eb3[j1]) * RDW'(r_ar[i][j2])
                              + RDW'(r_eb3[j2]) * RDW'(r_ar[i][j1]);
                n_p_x[i][j] = PW'(r_t[i2]) * PW'(r_rr[i1][j])
                            - PW'(r_t[i1]) * PW'(r_rr[i2][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad_a <= n_rad_a;
        r_rad_b <= n_rad_b;
        r_rad_x <= n_rad_x;
        r_p_b   <= n_p_b;
        r_p_x   <= n_p_x;
        r_t4    <= r_t;
    end

    // stage 5: any separating axis clears the result
    logic r_ok;
    logic n_ok;

    always_comb begin
        logic signed [CMPW-1:0] p, rad;
        n_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            p   = CMPW'(r_t4[i]);
            rad = CMPW'(r_rad_a[i]);
            if (((p < 0) ? -p : p) > rad) n_ok = 1'b0;
            p   = CMPW'(r_p_b[i]);
            rad = CMPW'(r_rad_b[i]) <<< QF;
            if (((p < 0) ? -p : p) > rad) n_ok = 1'b0;
            for (int j = 0; j < 3; j++) begin
                p   = CMPW'(r_p_x[i][j]);
                rad = CMPW'(r_rad_x[i][j]) <<< QF;
                if (((p < 0) ? -p : p) > rad) n_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
    end

    assign o_ok = r_ok;

endmodule

[hdl/obb_overlap_test_core.sv]
`timescale 1ns / 1ps
// each start emerges as the o_valid strobe carrying its result
// throughput: one word per cycle, busy is never raised (five register stages)
// the receiver cannot stall; each result shows for exactly one cycle
// reset (synchronous, active low) clears the valid pipeline and sets abs_bias to 1

module obb_overlap_test_core #(
    parameter int COORD_BITS = 21,
    parameter int QUAT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic [62:0] i_center_a,
    input  logic [62:0] i_center_b,
    input  logic [62:0] i_half_extents_a,
    input  logic [62:0] i_half_extents_b,
    input  logic [63:0] i_rotation_a,
    input  logic [63:0] i_rotation_b,
    input  logic        i_a_is_box,
    input  logic        i_b_is_box,
    output logic        o_valid,
    output logic        o_overlap
);
    localparam int CW = COORD_BITS;
    localparam int QB = QUAT_BITS;
    localparam int LAT = obb_pkg::LATENCY;

    logic [7:0] r_abs_bias;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_both;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_bias <= obb_pkg::ABS_BIAS_RESET;
            r_vld      <= '0;
        end else begin
            if (i_cfg_we) r_abs_bias <= i_cfg_wdata;
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_both <= {r_both[LAT-2:0], i_a_is_box & i_b_is_box};
    end

    // stage 1 and 2 side data
    logic signed [CW:0]   r_diff1 [3], r_diff2 [3];
    logic signed [CW-1:0] r_ea1 [3], r_ea2 [3], r_eb1 [3], r_eb2 [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_diff1[k] <= (CW + 1)'($signed(i_center_b[k*CW +: CW]))
                        - (CW + 1)'($signed(i_center_a[k*CW +: CW]));
            r_ea1[k]   <= $signed(i_half_extents_a[k*CW +: CW]);
            r_eb1[k]   <= $signed(i_half_extents_b[k*CW +: CW]);
        end
        r_diff2 <= r_diff1;
        r_ea2   <= r_ea1;
        r_eb2   <= r_eb1;
    end

    logic signed [QB-1:0] w_ma [3][3], w_mb [3][3];

    obb_quat_mat #(.QB(QB)) u_mat_a (
        .i_clk (i_clk),
        .i_w   ($signed(i_rotation_a[0*QB +: QB])),
        .i_x   ($signed(i_rotation_a[1*QB +: QB])),
        .i_y   ($signed(i_rotation_a[2*QB +: QB])),
        .i_z   ($signed(i_rotation_a[3*QB +: QB])),
        .o_m   (w_ma)
    );

    obb_quat_mat #(.QB(QB)) u_mat_b (
        .i_clk (i_clk),
        .i_w   ($signed(i_rotation_b[0*QB +: QB])),
        .i_x   ($signed(i_rotation_b[1*QB +: QB])),
        .i_y   ($signed(i_rotation_b[2*QB +: QB])),
        .i_z   ($signed(i_rotation_b[3*QB +: QB])),
        .o_m   (w_mb)
    );

    logic w_ok;

    obb_sat #(.CW(CW), .QB(QB)) u_sat (
        .i_clk  (i_clk),
        .i_bias (r_abs_bias),
        .i_ma   (w_ma),
        .i_mb   (w_mb),
        .i_diff (r_diff2),
        .i_ea   (r_ea2),
        .i_eb   (r_eb2),
        .o_ok   (w_ok)
    );

    assign o_valid   = r_vld[LAT-1];
    assign o_overlap = r_vld[LAT-1] & r_both[LAT-1] & w_ok;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without matching start");
    a_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_valid)
        else $error("accepted word produced no result");
    a_nobox: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !(i_a_is_box && i_b_is_box)) |-> ##5 !o_overlap)
        else $error("overlap reported for a non-box body");
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_overlap |-> o_valid)
        else $error("overlap high outside a result cycle");
`endif

endmodule
